// ===== src/b64e_pkg.sv =====
`timescale 1ns / 1ps

package b64e_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [1:0] LAST_SLOT   = 2'd3;
    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  n_pad;
        logic        last;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26) begin
            return 8'h41 + v8;
        end else if (v < 6'd52) begin
            return 8'h61 + (v8 - 8'd26);
        end else if (v < 6'd62) begin
            return 8'h30 + (v8 - 8'd52);
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

// ===== src/b64e_front.sv =====
`timescale 1ns / 1ps

module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_job_push,
    output t_job       o_job
);

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_held, n_held;

    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        o_job_push = 1'b0;
        o_job      = '0;
        if (i_accept) begin
            priority if (r_phase == PHASE_TWO) begin
                o_job_push = 1'b1;
                o_job.word = {r_held, i_data_byte};
                o_job.n_pad = 2'd0;
                o_job.last = i_end_of_message;
                n_phase    = PHASE_EMPTY;
                n_held     = '0;
            end else if (r_phase == PHASE_ONE) begin
                if (i_end_of_message) begin
                    o_job_push  = 1'b1;
                    o_job.word  = {r_held[7:0], i_data_byte, 8'h00};
                    o_job.n_pad = 2'd1;
                    o_job.last  = 1'b1;
                    n_phase     = PHASE_EMPTY;
                    n_held      = '0;
                end else begin
                    n_phase = PHASE_TWO;
                    n_held  = {r_held[7:0], i_data_byte};
                end
            end else begin
                if (i_end_of_message) begin
                    o_job_push  = 1'b1;
                    o_job.word  = {i_data_byte, 16'h0000};
                    o_job.n_pad = 2'd2;
                    o_job.last  = 1'b1;
                    n_phase     = PHASE_EMPTY;
                    n_held      = '0;
                end else begin
                    n_phase = PHASE_ONE;
                    n_held  = {8'h00, i_data_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_EMPTY;
            r_held  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    a_last_resets_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_end_of_message |=> r_phase == PHASE_EMPTY)
        else $error("phase not cleared after last byte");

endmodule

// ===== src/b64e_jobq.sv =====
`timescale 1ns / 1ps

module b64e_jobq
    import b64e_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("job queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into full queue");

endmodule

// ===== src/b64e_back.sv =====
`timescale 1ns / 1ps

module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_code_char,
    output logic       o_final_char
);

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_final;

    logic       emit, take, is_pad;
    logic [5:0] sextet;
    logic [7:0] n_char;

    assign emit      = r_busy && (!r_out_valid || i_pop);
    assign take      = i_job_valid && (!r_busy || (emit && r_idx == LAST_SLOT));
    assign o_job_pop = take;
    assign is_pad    = (r_idx > (LAST_SLOT - r_job.n_pad));

    always_comb begin
        unique case (r_idx)
            2'd0:    sextet = r_job.word[23:18];
            2'd1:    sextet = r_job.word[17:12];
            2'd2:    sextet = r_job.word[11:6];
            default: sextet = r_job.word[5:0];
        endcase
        n_char = is_pad ? PAD_CHAR : b64_char(sextet);
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out_char  <= n_char;
            r_out_final <= r_job.last && (r_idx == LAST_SLOT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == LAST_SLOT) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_code_char  = r_out_char;
    assign o_final_char = r_out_final;

    a_final_is_fourth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && r_idx != LAST_SLOT |=> !r_out_final)
        else $error("final flag on a non-closing character");

endmodule

// ===== src/base64_stream_encoder_core.sv =====
`timescale 1ns / 1ps
// channel  | handshake          | payload
// ---------+--------------------+----------------------------------------
// input    | push / full        | i_data_byte[7:0], i_end_of_message
// result   | empty / pop        | o_code_char[7:0], o_final_char
//
// Every third byte (or a flagged last byte) forms a group of four characters.
// The output serializer sends one character per cycle while the result
// register is empty or popped; a stalled pop holds it. The first character
// of a group passes through the job queue, the serializer's job register
// and the result register before it reaches the result ports. Reset is
// synchronous. full follows only the job queue between the byte packer and
// the serializer; a stalled pop backs up into it.

module base64_stream_encoder_core
    import b64e_pkg::*;
#(
    parameter int JOB_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_code_char,
    output logic       o_final_char
);

    logic accept;
    logic f_push, q_valid, q_pop;
    t_job f_job, q_job;

    assign accept = push && !full;

    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_job_push       (f_push),
        .o_job            (f_job)
    );

    b64e_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (q_job),
        .o_job_pop    (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_code_char  (o_code_char),
        .o_final_char (o_final_char)
    );

endmodule
